// ===== src/aabbtm_pkg.sv =====
// Shared types, constants and saturation helpers for the box transform/merge core.
// Used by the controller, the datapath, the top level and the port checker.
// No dependencies.
package aabbtm_pkg;

  // fixed-point format of every coordinate and matrix word
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned HALF_WIDTH  = COORD_WIDTH - 1;

  // accumulator wide enough for three rounded products plus a translation
  localparam int unsigned ACC_W   = 50;
  // shared multiplier operand and product widths
  localparam int unsigned MOP_W   = COORD_WIDTH + 1;
  localparam int unsigned PROD_W  = 2 * MOP_W;
  // squared row length, root iterations and quotient bits of the row scaling
  localparam int unsigned LSQ_W       = 2 * COORD_WIDTH;
  localparam int unsigned SQRT_STEPS  = COORD_WIDTH;
  localparam int unsigned DIV_STEPS   = FRAC_BITS + 1;
  localparam int unsigned NUM_W       = COORD_WIDTH + FRAC_BITS;
  localparam int unsigned MAT_WORDS   = 12;

  // transaction operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_XFORM = 2'd1;
  localparam logic [1:0] OP_MERGE = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [3:0]         matrix_index;
    logic signed [31:0] matrix_value;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic signed [31:0] box_center_z;
    logic [30:0]        box_half_x;
    logic [30:0]        box_half_y;
    logic [30:0]        box_half_z;
    logic               ignore_scale;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_center_x;
    logic signed [31:0] out_center_y;
    logic signed [31:0] out_center_z;
    logic [30:0]        out_half_x;
    logic [30:0]        out_half_y;
    logic [30:0]        out_half_z;
  } out_item_t;

  // datapath micro-operations issued by the controller
  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_SQ_CLR,
    DP_MUL_SQ,
    DP_ACC_SQ,
    DP_SQRT_INIT,
    DP_SQRT_STEP,
    DP_DIV_INIT,
    DP_DIV_STEP,
    DP_DIV_WRITE,
    DP_ROW_INIT,
    DP_MUL_CEN,
    DP_ACC_CEN,
    DP_MUL_HALF,
    DP_ACC_HALF,
    DP_ROW_WRITE,
    DP_MERGE_AXIS,
    DP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e     op;
    logic [1:0] row;
    logic [1:0] col;
  } dp_cmd_t;

  typedef struct packed {
    logic lsq_zero;
  } dp_status_t;

  // clamp to the signed coordinate range
  function automatic logic signed [COORD_WIDTH-1:0] sat_center(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [ACC_W-1:0] cmax;
    logic signed [ACC_W-1:0] cmin;
    cmax = {{(ACC_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    cmin = ~cmax;
    if (x > cmax) begin
      return cmax[COORD_WIDTH-1:0];
    end else if (x < cmin) begin
      return cmin[COORD_WIDTH-1:0];
    end
    return x[COORD_WIDTH-1:0];
  endfunction

  // clamp to the non-negative half-extent range
  function automatic logic [HALF_WIDTH-1:0] sat_half(
    input logic signed [ACC_W-1:0] x
  );
    logic signed [ACC_W-1:0] hmax;
    hmax = {{(ACC_W-HALF_WIDTH){1'b0}}, {HALF_WIDTH{1'b1}}};
    if (x < 0) begin
      return '0;
    end else if (x > hmax) begin
      return hmax[HALF_WIDTH-1:0];
    end
    return x[HALF_WIDTH-1:0];
  endfunction

endpackage

// ===== src/aabb_transform_merge_core.sv =====
// A transform runs the three matrix rows through the shared multiplier; with
// ignore_scale each matrix row is first checked and, if nonzero, scaled by a 32-step
// square root and three 17-step divisions. A merge works one axis at a time.
// One transaction in flight; the next is accepted once the result sits in the
// output register. A load writes the matrix on acceptance and leaves the core idle.
// Reset (async, active low) restores the identity matrix, zero translation and a zero current box.
module aabb_transform_merge_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  aabbtm_pkg::in_item_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output aabbtm_pkg::out_item_t out_data_o
);

  aabbtm_pkg::dp_cmd_t    cmd;
  aabbtm_pkg::dp_status_t status;

  // sequencer
  aabbtm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_op_i     (in_data_i.operation),
    .in_ignore_i (in_data_i.ignore_scale),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  aabbtm_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule

// ===== src/aabbtm_ctrl.sv =====
// Sequencer of the box transform/merge core: handshakes and micro-op issue.
// Depends on aabbtm_pkg; drives the datapath through aabbtm_pkg::dp_cmd_t.
module aabbtm_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic [1:0]             in_op_i,
  input  logic                   in_ignore_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  input  aabbtm_pkg::dp_status_t status_i,
  output aabbtm_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_SQ_CLR,
    S_SQ_MUL,
    S_SQ_ACC,
    S_SQ_CHK,
    S_SQRT_INIT,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DIV_WR,
    S_XF_INIT,
    S_XF_MULC,
    S_XF_ACCC,
    S_XF_MULH,
    S_XF_ACCH,
    S_XF_WR,
    S_MERGE,
    S_EMIT
  } state_e;

  state_e     state_q;
  logic [1:0] row_q;
  logic [1:0] col_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  // micro-op for the current state
  always_comb begin
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    case (state_q)
      S_IDLE:      cmd_o.op = in_valid_i ? aabbtm_pkg::DP_ACCEPT : aabbtm_pkg::DP_NOP;
      S_SQ_CLR:    cmd_o.op = aabbtm_pkg::DP_SQ_CLR;
      S_SQ_MUL:    cmd_o.op = aabbtm_pkg::DP_MUL_SQ;
      S_SQ_ACC:    cmd_o.op = aabbtm_pkg::DP_ACC_SQ;
      S_SQRT_INIT: cmd_o.op = aabbtm_pkg::DP_SQRT_INIT;
      S_SQRT:      cmd_o.op = aabbtm_pkg::DP_SQRT_STEP;
      S_DIV_INIT:  cmd_o.op = aabbtm_pkg::DP_DIV_INIT;
      S_DIV:       cmd_o.op = aabbtm_pkg::DP_DIV_STEP;
      S_DIV_WR:    cmd_o.op = aabbtm_pkg::DP_DIV_WRITE;
      S_XF_INIT:   cmd_o.op = aabbtm_pkg::DP_ROW_INIT;
      S_XF_MULC:   cmd_o.op = aabbtm_pkg::DP_MUL_CEN;
      S_XF_ACCC:   cmd_o.op = aabbtm_pkg::DP_ACC_CEN;
      S_XF_MULH:   cmd_o.op = aabbtm_pkg::DP_MUL_HALF;
      S_XF_ACCH:   cmd_o.op = aabbtm_pkg::DP_ACC_HALF;
      S_XF_WR:     cmd_o.op = aabbtm_pkg::DP_ROW_WRITE;
      S_MERGE:     cmd_o.op = aabbtm_pkg::DP_MERGE_AXIS;
      S_EMIT:      cmd_o.op = out_free ? aabbtm_pkg::DP_OUT_LOAD : aabbtm_pkg::DP_NOP;
      default:     cmd_o.op = aabbtm_pkg::DP_NOP;
    endcase
  end

  // state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_EMIT) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          row_q <= '0;
          col_q <= '0;
          if (in_valid_i) begin
            case (in_op_i)
              aabbtm_pkg::OP_XFORM: state_q <= in_ignore_i ? S_SQ_CLR : S_XF_INIT;
              aabbtm_pkg::OP_MERGE: state_q <= S_MERGE;
              default:              state_q <= S_IDLE;
            endcase
          end
        end
        S_SQ_CLR: begin
          col_q   <= '0;
          state_q <= S_SQ_MUL;
        end
        S_SQ_MUL: state_q <= S_SQ_ACC;
        S_SQ_ACC: begin
          if (col_q == 2'd2) begin
            state_q <= S_SQ_CHK;
          end else begin
            col_q   <= col_q + 2'd1;
            state_q <= S_SQ_MUL;
          end
        end
        S_SQ_CHK: begin
          if (!status_i.lsq_zero) begin
            state_q <= S_SQRT_INIT;
          end else if (row_q == 2'd2) begin
            row_q   <= '0;
            state_q <= S_XF_INIT;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_SQ_CLR;
          end
        end
        S_SQRT_INIT: begin
          step_q  <= '0;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (step_q == 5'(aabbtm_pkg::SQRT_STEPS - 1)) begin
            col_q   <= '0;
            state_q <= S_DIV_INIT;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        S_DIV_INIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (step_q == 5'(aabbtm_pkg::DIV_STEPS - 1)) begin
            state_q <= S_DIV_WR;
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        S_DIV_WR: begin
          if (col_q != 2'd2) begin
            col_q   <= col_q + 2'd1;
            state_q <= S_DIV_INIT;
          end else if (row_q == 2'd2) begin
            row_q   <= '0;
            state_q <= S_XF_INIT;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_SQ_CLR;
          end
        end
        S_XF_INIT: begin
          col_q   <= '0;
          state_q <= S_XF_MULC;
        end
        S_XF_MULC: state_q <= S_XF_ACCC;
        S_XF_ACCC: state_q <= S_XF_MULH;
        S_XF_MULH: state_q <= S_XF_ACCH;
        S_XF_ACCH: begin
          if (col_q == 2'd2) begin
            state_q <= S_XF_WR;
          end else begin
            col_q   <= col_q + 2'd1;
            state_q <= S_XF_MULC;
          end
        end
        S_XF_WR: begin
          if (row_q == 2'd2) begin
            state_q <= S_EMIT;
          end else begin
            row_q   <= row_q + 2'd1;
            state_q <= S_XF_INIT;
          end
        end
        S_MERGE: begin
          if (row_q == 2'd2) begin
            state_q <= S_EMIT;
          end else begin
            row_q <= row_q + 2'd1;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/aabbtm_datapath.sv =====
// Datapath of the box transform/merge core: matrix and box registers, shared
// multiplier, bit-serial square root and divider, merge logic, output register.
// Depends on aabbtm_pkg; commanded by aabbtm_ctrl.
module aabbtm_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  aabbtm_pkg::dp_cmd_t    cmd_i,
  input  aabbtm_pkg::in_item_t   in_data_i,
  output aabbtm_pkg::dp_status_t status_o,
  output aabbtm_pkg::out_item_t  out_data_o
);

  localparam int unsigned CW    = aabbtm_pkg::COORD_WIDTH;
  localparam int unsigned HW    = aabbtm_pkg::HALF_WIDTH;
  localparam int unsigned AW    = aabbtm_pkg::ACC_W;
  localparam int unsigned FB    = aabbtm_pkg::FRAC_BITS;
  localparam int unsigned MW    = aabbtm_pkg::MOP_W;
  localparam int unsigned PW    = aabbtm_pkg::PROD_W;
  localparam int unsigned LW    = aabbtm_pkg::LSQ_W;
  localparam int unsigned DS    = aabbtm_pkg::DIV_STEPS;
  localparam int unsigned NW    = aabbtm_pkg::NUM_W;

  // architectural state
  logic signed [CW-1:0] mat_q [aabbtm_pkg::MAT_WORDS];
  logic signed [CW-1:0] cur_c_q [3];
  logic [HW-1:0]        cur_h_q [3];

  // per-transaction working copies
  logic signed [CW-1:0] wm_q [9];
  logic signed [CW-1:0] in_c_q [3];
  logic [HW-1:0]        in_h_q [3];

  // arithmetic registers
  logic signed [PW-1:0] prod_q;
  logic signed [AW-1:0] acc_c_q;
  logic signed [AW-1:0] acc_h_q;
  logic [LW-1:0]        lsq_q;
  logic [LW-1:0]        sq_n_q;
  logic [CW:0]          sq_rem_q;
  logic [CW-1:0]        sq_root_q;
  logic [CW-1:0]        dv_rem_q;
  logic [DS-1:0]        dv_sh_q;
  logic [DS-1:0]        dv_quo_q;
  aabbtm_pkg::out_item_t out_q;

  // addressing
  logic [3:0]           idx;
  logic [3:0]           tr_idx;
  logic signed [CW-1:0] w_sel;
  logic [CW-1:0]        w_mag;

  assign idx    = ({2'b00, cmd_i.col} << 1) + {2'b00, cmd_i.col} + {2'b00, cmd_i.row};
  assign tr_idx = 4'd9 + {2'b00, cmd_i.row};
  assign w_sel  = wm_q[idx];
  assign w_mag  = w_sel[CW-1] ? CW'(-w_sel) : CW'(w_sel);

  assign status_o.lsq_zero = (lsq_q == '0);
  assign out_data_o        = out_q;

  // shared multiplier operand select
  logic signed [MW-1:0] mul_a;
  logic signed [MW-1:0] mul_b;
  logic                 mul_en;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      aabbtm_pkg::DP_MUL_SQ: begin
        mul_a = {1'b0, w_mag};
        mul_b = {1'b0, w_mag};
      end
      aabbtm_pkg::DP_MUL_CEN: begin
        mul_a = {w_sel[CW-1], w_sel};
        mul_b = {in_c_q[cmd_i.col][CW-1], in_c_q[cmd_i.col]};
      end
      aabbtm_pkg::DP_MUL_HALF: begin
        mul_a = {1'b0, w_mag};
        mul_b = {2'b00, in_h_q[cmd_i.col]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // product rounded half up to the coordinate format
  logic signed [PW:0]   prod_rnd;
  logic signed [AW-1:0] rnd;

  assign prod_rnd = {prod_q[PW-1], prod_q} + (PW+1)'(1 << (FB - 1));
  assign rnd      = prod_rnd[FB+AW-1:FB];

  // one square-root digit
  logic [CW+2:0] sq_rem2;
  logic [CW+2:0] sq_trial;
  logic          sq_ge;

  assign sq_rem2  = {sq_rem_q, sq_n_q[LW-1:LW-2]};
  assign sq_trial = {1'b0, sq_root_q, 2'b01};
  assign sq_ge    = (sq_rem2 >= sq_trial);

  // divider numerator and one quotient bit
  logic [NW-1:0] dv_num;
  logic [CW:0]   dv_t;
  logic          dv_ge;

  assign dv_num = {w_mag, {FB{1'b0}}} + NW'(sq_root_q >> 1);
  assign dv_t   = {dv_rem_q, dv_sh_q[DS-1]};
  assign dv_ge  = (dv_t >= {1'b0, sq_root_q});

  // merge of one axis
  logic signed [CW+1:0] m_cc;
  logic signed [CW+1:0] m_ch;
  logic signed [CW+1:0] m_ic;
  logic signed [CW+1:0] m_ih;
  logic signed [CW+1:0] m_lo;
  logic signed [CW+1:0] m_hi;
  logic signed [CW+2:0] m_sum;
  logic signed [CW+2:0] m_dif;
  logic signed [AW-1:0] m_ctr;
  logic signed [AW-1:0] m_half;

  always_comb begin
    m_cc  = {{2{cur_c_q[cmd_i.row][CW-1]}}, cur_c_q[cmd_i.row]};
    m_ch  = {3'b000, cur_h_q[cmd_i.row]};
    m_ic  = {{2{in_c_q[cmd_i.row][CW-1]}}, in_c_q[cmd_i.row]};
    m_ih  = {3'b000, in_h_q[cmd_i.row]};
    m_lo  = m_cc - m_ch;
    m_hi  = m_cc + m_ch;
    if ((m_ic - m_ih) < m_lo) begin
      m_lo = m_ic - m_ih;
    end
    if ((m_ic + m_ih) > m_hi) begin
      m_hi = m_ic + m_ih;
    end
    m_sum  = $signed({m_lo[CW+1], m_lo} + {m_hi[CW+1], m_hi}) >>> 1;
    m_dif  = ({m_hi[CW+1], m_hi} - {m_lo[CW+1], m_lo} + (CW+3)'(1)) >>> 1;
    m_ctr  = {{(AW-CW-3){m_sum[CW+2]}}, m_sum};
    m_half = {{(AW-CW-3){m_dif[CW+2]}}, m_dif};
  end

  // matrix and current box, reset to the identity matrix and a zero box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < aabbtm_pkg::MAT_WORDS; k++) begin
        mat_q[k] <= (k == 0 || k == 4 || k == 8) ? CW'(1 << FB) : CW'(0);
      end
      for (int k = 0; k < 3; k++) begin
        cur_c_q[k] <= '0;
        cur_h_q[k] <= '0;
      end
    end else begin
      case (cmd_i.op)
        aabbtm_pkg::DP_ACCEPT: begin
          if (in_data_i.operation == aabbtm_pkg::OP_LOAD &&
              in_data_i.matrix_index < 4'(aabbtm_pkg::MAT_WORDS)) begin
            mat_q[in_data_i.matrix_index] <= in_data_i.matrix_value;
          end
        end
        aabbtm_pkg::DP_ROW_WRITE: begin
          cur_c_q[cmd_i.row] <= aabbtm_pkg::sat_center(acc_c_q);
          cur_h_q[cmd_i.row] <= aabbtm_pkg::sat_half(acc_h_q);
        end
        aabbtm_pkg::DP_MERGE_AXIS: begin
          cur_c_q[cmd_i.row] <= aabbtm_pkg::sat_center(m_ctr);
          cur_h_q[cmd_i.row] <= aabbtm_pkg::sat_half(m_half);
        end
        default: ;
      endcase
    end
  end

  // working registers and arithmetic units
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      aabbtm_pkg::DP_ACCEPT: begin
        for (int k = 0; k < 9; k++) begin
          wm_q[k] <= mat_q[k];
        end
        in_c_q[0] <= in_data_i.box_center_x;
        in_c_q[1] <= in_data_i.box_center_y;
        in_c_q[2] <= in_data_i.box_center_z;
        in_h_q[0] <= in_data_i.box_half_x;
        in_h_q[1] <= in_data_i.box_half_y;
        in_h_q[2] <= in_data_i.box_half_z;
      end
      aabbtm_pkg::DP_SQ_CLR:  lsq_q <= '0;
      aabbtm_pkg::DP_ACC_SQ:  lsq_q <= lsq_q + prod_q[LW-1:0];
      aabbtm_pkg::DP_SQRT_INIT: begin
        sq_n_q    <= lsq_q;
        sq_rem_q  <= '0;
        sq_root_q <= '0;
      end
      aabbtm_pkg::DP_SQRT_STEP: begin
        sq_rem_q  <= sq_ge ? (CW+1)'(sq_rem2 - sq_trial) : (CW+1)'(sq_rem2);
        sq_root_q <= {sq_root_q[CW-2:0], sq_ge};
        sq_n_q    <= sq_n_q << 2;
      end
      aabbtm_pkg::DP_DIV_INIT: begin
        dv_rem_q <= CW'(dv_num[NW-1:DS]);
        dv_sh_q  <= dv_num[DS-1:0];
        dv_quo_q <= '0;
      end
      aabbtm_pkg::DP_DIV_STEP: begin
        dv_rem_q <= dv_ge ? CW'(dv_t - {1'b0, sq_root_q}) : dv_t[CW-1:0];
        dv_sh_q  <= dv_sh_q << 1;
        dv_quo_q <= {dv_quo_q[DS-2:0], dv_ge};
      end
      aabbtm_pkg::DP_DIV_WRITE: begin
        wm_q[idx] <= w_sel[CW-1] ? -CW'(dv_quo_q) : CW'(dv_quo_q);
      end
      aabbtm_pkg::DP_ROW_INIT: begin
        acc_c_q <= AW'(mat_q[tr_idx]);
        acc_h_q <= '0;
      end
      aabbtm_pkg::DP_ACC_CEN:  acc_c_q <= acc_c_q + rnd;
      aabbtm_pkg::DP_ACC_HALF: acc_h_q <= acc_h_q + rnd;
      aabbtm_pkg::DP_OUT_LOAD: begin
        out_q.out_center_x <= cur_c_q[0];
        out_q.out_center_y <= cur_c_q[1];
        out_q.out_center_z <= cur_c_q[2];
        out_q.out_half_x   <= cur_h_q[0];
        out_q.out_half_y   <= cur_h_q[1];
        out_q.out_half_z   <= cur_h_q[2];
      end
      default: ;
    endcase
  end

endmodule

// ===== src/aabbtm_checker.sv =====
// Port-level checks for the box transform/merge core, bound to the top level.
// Depends on aabbtm_pkg and aabb_transform_merge_core.
module aabbtm_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input aabbtm_pkg::in_item_t  in_data_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input aabbtm_pkg::out_item_t out_data_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a load never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.operation == aabbtm_pkg::OP_LOAD
    |=> !$rose(out_valid_o))
    else $error("result after load transaction");

  // transform and merge occupy the core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o &&
    (in_data_i.operation == aabbtm_pkg::OP_XFORM ||
     in_data_i.operation == aabbtm_pkg::OP_MERGE)
    |=> in_stall_o)
    else $error("core free right after box transaction");

  // a new result only comes out of a busy core
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without work in progress");

endmodule

bind aabb_transform_merge_core aabbtm_checker u_aabbtm_checker (.*);
